// File: hw/rtl/svre_pkg.sv
// Package for the split virtqueue ring engine: field widths, item and status
// codes, register indexes and the descriptor and result structures.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package svre_pkg;

    localparam int RING_IDX_W = 8;
    localparam int RING_DEPTH = 1 << RING_IDX_W;
    localparam int SIZE_W     = RING_IDX_W + 1;
    localparam int LG_W       = 4;
    localparam int CNT_W      = 16;
    localparam int CHAIN_W    = 17;
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 32;
    localparam int FLAGS_W    = 16;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int F_NEXT_BIT = 0;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [LG_W-1:0] SIZE_LOG2_RESET = 4'd8;

    // Register index as decoded from paddr[2].
    localparam logic REG_SIZE_LOG2 = 1'b0;
    localparam logic REG_READY     = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 2'd0,
        KIND_POST    = 2'd1,
        KIND_RECLAIM = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        logic [LEN_W-1:0]      len;
        logic [FLAGS_W-1:0]    flags;
        logic [RING_IDX_W-1:0] link;
    } t_desc;

    typedef struct packed {
        t_status               status;
        logic [RING_IDX_W-1:0] table_index;
        logic [RING_IDX_W-1:0] next_link;
        logic [FLAGS_W-1:0]    flags_written;
        logic                  published;
        logic [RING_IDX_W-1:0] avail_slot;
        logic [RING_IDX_W-1:0] chain_head;
        logic [CNT_W-1:0]      avail_counter_out;
        logic [LEN_W-1:0]      completion_len;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/svre_in_if.sv
// Command channel of the ring engine: valid/ready plus one item's fields.
// Depends on svre_pkg for the field widths.
`default_nettype none

interface svre_in_if
    import svre_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   desc_addr;
    logic [LEN_W-1:0]    desc_len;
    logic [FLAGS_W-1:0]  desc_flags;
    logic [CNT_W-1:0]    out_count;
    logic [CNT_W-1:0]    in_count;
    logic [LEN_W-1:0]    posted_len;

    modport source (
        output valid, kind, desc_addr, desc_len, desc_flags, out_count, in_count,
               posted_len,
        input  ready
    );
    modport sink (
        input  valid, kind, desc_addr, desc_len, desc_flags, out_count, in_count,
               posted_len,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/svre_out_if.sv
// Response channel of the ring engine: valid/ready plus one result's fields.
// Depends on svre_pkg for the field widths.
`default_nettype none

interface svre_out_if
    import svre_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [RING_IDX_W-1:0] table_index;
    logic [RING_IDX_W-1:0] next_link;
    logic [FLAGS_W-1:0]    flags_written;
    logic                  published;
    logic [RING_IDX_W-1:0] avail_slot;
    logic [RING_IDX_W-1:0] chain_head;
    logic [CNT_W-1:0]      avail_counter_out;
    logic [LEN_W-1:0]      completion_len;

    modport source (
        output valid, status, table_index, next_link, flags_written, published,
               avail_slot, chain_head, avail_counter_out, completion_len,
        input  ready
    );
    modport sink (
        input  valid, status, table_index, next_link, flags_written, published,
               avail_slot, chain_head, avail_counter_out, completion_len,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/split_virtqueue_ring_engine_unit.sv
// Top level of the split virtqueue ring engine (driver side).
// Depends on svre_pkg and on the svre_in_if / svre_out_if channel interfaces.
// Holds the descriptor table, the available ring and the used-length ring.
//
//   Channel   Dir  Handshake               Carries
//   i_cmd     in   valid/ready             add element, device post or reclaim
//   o_rsp     out  valid/ready             status, slots, flags, used length
//   APB       in   psel/penable/pwrite     queue_size_log2, queue_ready
//
// One item can be accepted every cycle while input does not stall (see below). Its
// result goes through the middle stage to the output register: the accepting edge
// updates the counters, writes the memories, reads the used-length ring and loads
// the middle stage, which moves on once the output register is free. The registered
// used-length ring read sets that depth. Reset clears all counters, the chain
// tracking and the valid flags of both registers. While the output register is full
// and not taken, the middle stage holds, and once it is full as well, input stalls.
`default_nettype none

module split_virtqueue_ring_engine_unit
    import svre_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    svre_in_if.sink                 i_cmd,
    svre_out_if.source              o_rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // Largest ring size, as a log2, that fits both the memories and MAX_ENTRIES.
    localparam int LG_FLOOR = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int LG_CAP   = (LG_FLOOR > RING_IDX_W) ? RING_IDX_W : LG_FLOOR;
    localparam logic [LG_W-1:0] LG_CAP_C = LG_W'(LG_CAP);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [LG_W-1:0] r_size_log2;
    logic            r_queue_ready;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2   <= SIZE_LOG2_RESET;
            r_queue_ready <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SIZE_LOG2) begin
                r_size_log2 <= pwdata[LG_W-1:0];
            end else begin
                r_queue_ready <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_READY) begin
            prdata = {{(PDATA_W-1){1'b0}}, r_queue_ready};
        end else begin
            prdata = {{(PDATA_W-LG_W){1'b0}}, r_size_log2};
        end
    end

    // ------------------------------------------------------------------
    // Control state and memories.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      r_avail_cnt,  n_avail_cnt;
    logic [RING_IDX_W-1:0] r_next_free,  n_next_free;
    logic [CHAIN_W-1:0]    r_chain_pos,  n_chain_pos;
    logic [CHAIN_W-1:0]    r_chain_tot,  n_chain_tot;
    logic [CNT_W-1:0]      r_dev_cnt,    n_dev_cnt;
    logic [CNT_W-1:0]      r_recl_cnt,   n_recl_cnt;

    t_desc                 desc_mem   [RING_DEPTH];
    logic [RING_IDX_W-1:0] avail_mem  [RING_DEPTH];
    logic [LEN_W-1:0]      used_mem   [RING_DEPTH];
    logic [LEN_W-1:0]      r_used_rdata;

    // Middle stage and output register.
    t_result r_s1, r_out, res;
    logic    r_s1_valid, r_s1_fwd, r_out_valid;
    logic    out_free, s1_move, in_acc;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_cmd.ready = !r_s1_valid || out_free;
    assign in_acc      = i_cmd.valid && i_cmd.ready;

    // ------------------------------------------------------------------
    // Item decode: ring geometry, chain arithmetic and next state.
    // ------------------------------------------------------------------
    logic [LG_W-1:0]       lg_eff;
    logic [SIZE_W-1:0]     ring_size;
    logic [RING_IDX_W-1:0] ring_mask;
    logic [RING_IDX_W-1:0] head, idx, link_n, avail_slot;
    logic [CHAIN_W-1:0]    sum_cnt, tot;
    logic [CNT_W-1:0]      avail_inc;
    logic                  last, first, desc_we, avail_we, used_we, rd_hit;
    logic [FLAGS_W-1:0]    flags_n;
    logic [RING_IDX_W-1:0] used_waddr, used_raddr;

    always_comb begin
        lg_eff     = (r_size_log2 > LG_CAP_C) ? LG_CAP_C : r_size_log2;
        ring_size  = SIZE_W'(1) << lg_eff;
        ring_mask  = RING_IDX_W'(ring_size - SIZE_W'(1));
        head       = r_next_free & ring_mask;
        first      = (r_chain_pos == '0);
        sum_cnt    = {1'b0, i_cmd.out_count} + {1'b0, i_cmd.in_count};
        tot        = first ? sum_cnt : r_chain_tot;
        idx        = (head + r_chain_pos[RING_IDX_W-1:0]) & ring_mask;
        last       = ({1'b0, r_chain_pos} + (CHAIN_W+1)'(1)) >= {1'b0, tot};
        link_n     = (idx + RING_IDX_W'(1)) & ring_mask;
        avail_slot = r_avail_cnt[RING_IDX_W-1:0] & ring_mask;
        avail_inc  = r_avail_cnt + CNT_W'(1);
        used_waddr = r_dev_cnt[RING_IDX_W-1:0] & ring_mask;
        used_raddr = r_recl_cnt[RING_IDX_W-1:0] & ring_mask;
        flags_n    = i_cmd.desc_flags;
        flags_n[F_NEXT_BIT] = !last;

        res         = '0;
        res.status  = ST_OK;
        n_avail_cnt = r_avail_cnt;
        n_next_free = r_next_free;
        n_chain_pos = r_chain_pos;
        n_chain_tot = r_chain_tot;
        n_dev_cnt   = r_dev_cnt;
        n_recl_cnt  = r_recl_cnt;
        desc_we     = 1'b0;
        avail_we    = 1'b0;
        used_we     = 1'b0;
        rd_hit      = 1'b0;

        if (!r_queue_ready) begin
            res.status = ST_INVALID;
        end else begin
            unique case (i_cmd.kind)
                KIND_ADD: begin
                    // The chain total is checked on its first element only.
                    if (first && (sum_cnt == '0 ||
                                  sum_cnt > {{(CHAIN_W-SIZE_W){1'b0}}, ring_size})) begin
                        res.status = ST_INVALID;
                    end else begin
                        desc_we           = 1'b1;
                        n_chain_tot       = tot;
                        res.table_index   = idx;
                        res.flags_written = flags_n;
                        if (!last) begin
                            res.next_link = link_n;
                            n_chain_pos   = r_chain_pos + CHAIN_W'(1);
                        end else begin
                            // Closing element: publish the head to the available ring.
                            avail_we              = 1'b1;
                            n_avail_cnt           = avail_inc;
                            n_next_free           = (head + tot[RING_IDX_W-1:0]) & ring_mask;
                            n_chain_pos           = '0;
                            res.published         = 1'b1;
                            res.avail_slot        = avail_slot;
                            res.chain_head        = head;
                            res.avail_counter_out = avail_inc;
                        end
                    end
                end
                KIND_POST: begin
                    used_we   = 1'b1;
                    n_dev_cnt = r_dev_cnt + CNT_W'(1);
                end
                KIND_RECLAIM: begin
                    if (r_recl_cnt == r_dev_cnt) begin
                        res.status = ST_EMPTY;
                    end else begin
                        rd_hit     = 1'b1;
                        n_recl_cnt = r_recl_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    res.status = ST_INVALID;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Memories. A post and a later reclaim of the same entry are always at
    // different edges, so the read sees the write without forwarding.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && desc_we) begin
            desc_mem[idx] <= '{addr:  i_cmd.desc_addr,
                               len:   i_cmd.desc_len,
                               flags: flags_n,
                               link:  res.next_link};
        end
        if (in_acc && avail_we) begin
            avail_mem[avail_slot] <= head;
        end
        if (in_acc && used_we) begin
            used_mem[used_waddr] <= i_cmd.posted_len;
        end
        if (in_acc) begin
            r_used_rdata <= used_mem[used_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail_cnt <= '0;
            r_next_free <= '0;
            r_chain_pos <= '0;
            r_chain_tot <= '0;
            r_dev_cnt   <= '0;
            r_recl_cnt  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_avail_cnt <= n_avail_cnt;
                r_next_free <= n_next_free;
                r_chain_pos <= n_chain_pos;
                r_chain_tot <= n_chain_tot;
                r_dev_cnt   <= n_dev_cnt;
                r_recl_cnt  <= n_recl_cnt;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1     <= res;
            r_s1_fwd <= rd_hit;
        end
        if (s1_move) begin
            r_out <= r_s1;
            if (r_s1_fwd) begin
                r_out.completion_len <= r_used_rdata;
            end
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_out.status;
    assign o_rsp.table_index       = r_out.table_index;
    assign o_rsp.next_link         = r_out.next_link;
    assign o_rsp.flags_written     = r_out.flags_written;
    assign o_rsp.published         = r_out.published;
    assign o_rsp.avail_slot        = r_out.avail_slot;
    assign o_rsp.chain_head        = r_out.chain_head;
    assign o_rsp.avail_counter_out = r_out.avail_counter_out;
    assign o_rsp.completion_len    = r_out.completion_len;

`ifndef SYNTHESIS
    // An open chain always has elements left to take.
    a_chain_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chain_pos != '0 |-> r_chain_tot > r_chain_pos)
        else $error("chain position reached chain total");

    // The middle stage is never overwritten while it still holds a beat.
    a_s1_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_s1_valid |-> out_free)
        else $error("middle stage overwritten");

    // A stalled middle stage keeps its beat.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1))
        else $error("middle stage changed while stalled");

    // A successful reclaim only happens while posts are outstanding.
    a_reclaim_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && rd_hit |-> r_recl_cnt != r_dev_cnt)
        else $error("reclaim passed the device counter");
`endif

endmodule

`default_nettype wire

// File: dv/split_virtqueue_ring_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the split virtqueue ring engine, driver side.
// It needs svre_pkg, the svre_in_if / svre_out_if interfaces and the
// split_virtqueue_ring_engine_unit top level.

module split_virtqueue_ring_engine_unit_tb;
    import svre_pkg::*;

    // Kind code 3 is not a defined operation; the block must reject it.
    localparam logic [KIND_W-1:0] KIND_UNDEFINED = 2'd3;
    localparam int CYCLE_LIMIT = 150000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 75;

    // One command beat as the sender sees it.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  desc_addr;
        logic [LEN_W-1:0]   desc_len;
        logic [FLAGS_W-1:0] desc_flags;
        logic [CNT_W-1:0]   out_count;
        logic [CNT_W-1:0]   in_count;
        logic [LEN_W-1:0]   posted_len;
    } ring_cmd_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    svre_in_if  cmd_if ();
    svre_out_if rsp_if ();

    split_virtqueue_ring_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the engine state. The descriptor table and the available
    // ring are never read back by the block, so only the used-length ring is
    // mirrored, together with a flag per entry that records whether the device
    // side ever wrote it.
    logic [LG_W-1:0]    cfg_size_log2 = SIZE_LOG2_RESET;
    logic               cfg_ready = 1'b0;
    logic [LEN_W-1:0]   used_len_ring [RING_DEPTH];
    bit                 used_len_valid [RING_DEPTH];
    logic [CNT_W-1:0]   avail_cnt = '0;
    logic [7:0]         next_free_slot = '0;
    logic [CHAIN_W-1:0] chain_pos = '0;
    logic [CHAIN_W-1:0] chain_len = '0;
    logic [CNT_W-1:0]   device_used_cnt = '0;
    logic [CNT_W-1:0]   reclaimed_cnt = '0;

    // Results the block still owes us, oldest first.
    t_result ring_results_q[$];

    int fail_count = 0;
    int cycle_count = 0;
    int cmd_gap_max = 6;
    int rsp_stall_max = 6;
    int rsp_stall_left = 0;
    int rsp_beat_count = 0;
    int rsp_beat_seen = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run-away guard. The run is stopped and reported as failed at CYCLE_LIMIT,
    // which only trips on a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The ring size in use saturates at the physical depth of 256 entries.
    function automatic int ring_size_now();
        int lg;
        lg = (cfg_size_log2 > 4'd8) ? 8 : int'(cfg_size_log2);
        return 1 << lg;
    endfunction

    function automatic logic [7:0] ring_mask_now();
        return 8'(ring_size_now() - 1);
    endfunction

    // Advances the shadow state by one accepted beat and returns the result
    // that beat must produce.
    function automatic t_result ring_engine_step(ring_cmd_t c);
        t_result            r;
        int                 size;
        logic [7:0]         mask;
        logic [7:0]         head;
        logic [7:0]         idx;
        logic [7:0]         link;
        logic [7:0]         slot;
        logic [FLAGS_W-1:0] flags;
        logic [CHAIN_W-1:0] total;
        bit                 last;

        r = '0;
        size = ring_size_now();
        mask = ring_mask_now();
        if (!cfg_ready || c.kind > KIND_RECLAIM) begin
            r.status = ST_INVALID;
            return r;
        end
        case (c.kind)
            KIND_ADD: begin
                head = next_free_slot & mask;
                if (chain_pos == '0) begin
                    // The total is formed at 17 bits, so 65535 + 2 does not
                    // wrap to a legal small chain.
                    total = {1'b0, c.out_count} + {1'b0, c.in_count};
                    if (total == '0 || total > size) begin
                        r.status = ST_INVALID;
                        return r;
                    end
                    chain_len = total;
                end
                idx = 8'(head + chain_pos) & mask;
                last = ({1'b0, chain_pos} + 18'd1 >= {1'b0, chain_len});
                flags = c.desc_flags;
                link = '0;
                if (!last) begin
                    flags[F_NEXT_BIT] = 1'b1;
                    link = 8'(idx + 1) & mask;
                end else begin
                    flags[F_NEXT_BIT] = 1'b0;
                end
                r.table_index = idx;
                r.next_link = link;
                r.flags_written = flags;
                if (last) begin
                    slot = avail_cnt[7:0] & mask;
                    avail_cnt = avail_cnt + 1'b1;
                    next_free_slot = 8'(head + chain_len[7:0]) & mask;
                    chain_pos = '0;
                    r.published = 1'b1;
                    r.avail_slot = slot;
                    r.chain_head = head;
                    r.avail_counter_out = avail_cnt;
                end else begin
                    chain_pos = chain_pos + 1'b1;
                end
            end
            KIND_POST: begin
                used_len_ring[device_used_cnt[7:0] & mask] = c.posted_len;
                used_len_valid[device_used_cnt[7:0] & mask] = 1'b1;
                device_used_cnt = device_used_cnt + 1'b1;
            end
            default: begin
                if (reclaimed_cnt == device_used_cnt) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.completion_len = used_len_ring[reclaimed_cnt[7:0] & mask];
                    reclaimed_cnt = reclaimed_cnt + 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic ring_cmd_t random_cmd(logic [KIND_W-1:0] kind);
        ring_cmd_t c;
        c.kind = kind;
        c.desc_addr = {$urandom, $urandom};
        c.desc_len = $urandom;
        c.desc_flags = FLAGS_W'($urandom);
        c.out_count = CNT_W'($urandom);
        c.in_count = CNT_W'($urandom);
        c.posted_len = $urandom;
        return c;
    endfunction

    // Sends one command beat after a random gap. The valid line stays high
    // into the next call when no gap is drawn, so back-to-back beats occur.
    task automatic send_cmd(ring_cmd_t c);
        int gap;
        gap = $urandom_range(0, cmd_gap_max);
        @(negedge i_clk);
        repeat (gap) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        // A reclaim must never land on a used entry that the device side has
        // not written since reset; that can only follow a size change. Such a
        // beat is turned into a device post instead.
        if (c.kind == KIND_RECLAIM && cfg_ready && reclaimed_cnt != device_used_cnt
                && !used_len_valid[reclaimed_cnt[7:0] & ring_mask_now()]) begin
            c.kind = KIND_POST;
        end
        ring_results_q.push_back(ring_engine_step(c));
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= c.kind;
        cmd_if.desc_addr  <= c.desc_addr;
        cmd_if.desc_len   <= c.desc_len;
        cmd_if.desc_flags <= c.desc_flags;
        cmd_if.out_count  <= c.out_count;
        cmd_if.in_count   <= c.in_count;
        cmd_if.posted_len <= c.posted_len;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
    endtask

    // Lowers valid and waits until every owed result has come back and the
    // two-stage pipeline has settled.
    task automatic drain_ring();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (ring_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write with a setup and an access phase; the shadow copy follows at the access edge.
    task automatic reg_write(logic reg_idx, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (reg_idx == REG_SIZE_LOG2) begin
            cfg_size_log2 = value[LG_W-1:0];
        end else begin
            cfg_ready = value[0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [LG_W-1:0] size_log2, logic ready);
        drain_ring();
        reg_write(REG_SIZE_LOG2, PDATA_W'(size_log2));
        reg_write(REG_READY, PDATA_W'(ready));
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result checker: every response beat is matched against the oldest
    // outstanding prediction, one field at a time.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            rsp_beat_count++;
            if (ring_results_q.size() == 0) begin
                $display("%0t: response beat with no result outstanding, expected none, got status %0d",
                         $time, rsp_if.status);
                fail_count++;
            end else begin
                exp_r = ring_results_q.pop_front();
                check_field("status", 32'(exp_r.status), 32'(rsp_if.status));
                check_field("table_index", 32'(exp_r.table_index), 32'(rsp_if.table_index));
                check_field("next_link", 32'(exp_r.next_link), 32'(rsp_if.next_link));
                check_field("flags_written", 32'(exp_r.flags_written),
                            32'(rsp_if.flags_written));
                check_field("published", 32'(exp_r.published), 32'(rsp_if.published));
                check_field("avail_slot", 32'(exp_r.avail_slot), 32'(rsp_if.avail_slot));
                check_field("chain_head", 32'(exp_r.chain_head), 32'(rsp_if.chain_head));
                check_field("avail_counter_out", 32'(exp_r.avail_counter_out),
                            32'(rsp_if.avail_counter_out));
                check_field("completion_len", exp_r.completion_len, rsp_if.completion_len);
            end
        end
    end

    // Response back-pressure: after each taken beat a fresh stall length is
    // drawn, so the stalls back up into every stage of the pipeline over the run.
    always @(negedge i_clk) begin
        if (rsp_beat_seen != rsp_beat_count) begin
            rsp_beat_seen = rsp_beat_count;
            rsp_stall_left = $urandom_range(0, rsp_stall_max);
        end
        if (rsp_stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left--;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Out of reset the queue is not ready, so every kind is refused.
    task automatic test_queue_not_ready();
        send_cmd(random_cmd(KIND_ADD));
        send_cmd(random_cmd(KIND_POST));
        send_cmd(random_cmd(KIND_RECLAIM));
    endtask

    // Chain totals of zero, beyond the ring, and one that would look legal if
    // the sum wrapped at 16 bits. An undefined kind is refused as well.
    task automatic test_bad_chain_totals();
        ring_cmd_t c;
        configure(4'd8, 1'b1);
        c = random_cmd(KIND_ADD);
        c.out_count = '0;
        c.in_count = '0;
        send_cmd(c);
        c.out_count = '1;
        c.in_count = 16'd2;
        send_cmd(c);
        c.out_count = 16'd200;
        c.in_count = 16'd57;
        send_cmd(c);
        send_cmd(random_cmd(KIND_UNDEFINED));
    endtask

    task automatic test_reclaim_empty();
        send_cmd(random_cmd(KIND_RECLAIM));
    endtask

    // A one-element chain with address, length and flags at their maximum, then a three
    // element chain with zero fields and an invalid beat inside it. The counts
    // on later elements are ignored, so they are set to their maximum.
    task automatic test_chain_elements();
        ring_cmd_t c;
        c = random_cmd(KIND_ADD);
        c.desc_addr = '1;
        c.desc_len = '1;
        c.desc_flags = '1;
        c.out_count = 16'd1;
        c.in_count = '0;
        send_cmd(c);
        c = '0;
        c.kind = KIND_ADD;
        c.out_count = 16'd2;
        c.in_count = 16'd1;
        send_cmd(c);
        send_cmd(random_cmd(KIND_UNDEFINED));
        c.out_count = '1;
        c.in_count = '1;
        send_cmd(c);
        c.desc_flags = '1;
        send_cmd(c);
    endtask

    task automatic test_post_and_reclaim();
        ring_cmd_t c;
        c = random_cmd(KIND_POST);
        c.posted_len = '1;
        send_cmd(c);
        c.posted_len = '0;
        send_cmd(c);
        send_cmd(random_cmd(KIND_RECLAIM));
        send_cmd(random_cmd(KIND_RECLAIM));
    endtask

    // A four-element chain opened on the full ring is finished after the ring
    // shrinks to two entries, then a chain on a one-entry ring follows.
    task automatic test_resize_mid_chain();
        ring_cmd_t c;
        c = random_cmd(KIND_ADD);
        c.out_count = '0;
        c.in_count = 16'd4;
        send_cmd(c);
        send_cmd(random_cmd(KIND_ADD));
        configure(4'd1, 1'b1);
        send_cmd(random_cmd(KIND_ADD));
        send_cmd(random_cmd(KIND_ADD));
        configure(4'd0, 1'b1);
        c = random_cmd(KIND_ADD);
        c.out_count = '0;
        c.in_count = 16'd1;
        send_cmd(c);
    endtask

    // On a one-entry ring a second post overwrites the first length before
    // it is reclaimed, so the first two reclaims return the later value and the third finds the ring empty.
    task automatic test_device_overrun();
        send_cmd(random_cmd(KIND_POST));
        send_cmd(random_cmd(KIND_POST));
        send_cmd(random_cmd(KIND_RECLAIM));
        send_cmd(random_cmd(KIND_RECLAIM));
        send_cmd(random_cmd(KIND_RECLAIM));
    endtask

    // Mostly well-formed chains with random content, mixed with posts,
    // reclaims and malformed beats.
    task automatic run_traffic_phase(int n_items);
        int        sent;
        int        pick;
        int        total;
        int        limit;
        ring_cmd_t c;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                limit = (ring_size_now() < 6) ? ring_size_now() : 6;
                if (ring_size_now() <= 32 && $urandom_range(0, 9) == 0) begin
                    limit = ring_size_now();
                end
                total = $urandom_range(1, limit);
                for (int k = 0; k < total; k++) begin
                    c = random_cmd(KIND_ADD);
                    if (k == 0) begin
                        c.out_count = CNT_W'($urandom_range(0, total));
                        c.in_count = CNT_W'(total - int'(c.out_count));
                    end
                    // Now and then a stray beat lands inside the open chain.
                    if ($urandom_range(0, 19) == 0) begin
                        send_cmd(random_cmd(KIND_W'($urandom_range(1, 3))));
                        sent++;
                    end
                    send_cmd(c);
                    sent++;
                end
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 3)) begin
                    send_cmd(random_cmd(KIND_POST));
                    sent++;
                end
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) begin
                    send_cmd(random_cmd(KIND_RECLAIM));
                    sent++;
                end
            end else begin
                send_cmd(random_cmd(KIND_W'($urandom_range(0, 3))));
                sent++;
            end
        end
    endtask

    // Each phase runs under a new ring size, the extremes first. Idling is
    // either off on a side or drawn at random, so both dense and sparse
    // traffic appear. The drain before each write makes the sender wait for
    // every result to come back.
    task automatic test_random_traffic();
        logic [LG_W-1:0] size_log2;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       size_log2 = 4'd15;
                1:       size_log2 = 4'd0;
                2:       size_log2 = 4'd8;
                3:       size_log2 = 4'd2;
                default: size_log2 = LG_W'($urandom_range(0, 15));
            endcase
            configure(size_log2, 1'b1);
            cmd_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            run_traffic_phase(PHASE_ITEMS);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.kind = KIND_ADD;
        cmd_if.desc_addr = '0;
        cmd_if.desc_len = '0;
        cmd_if.desc_flags = '0;
        cmd_if.out_count = '0;
        cmd_if.in_count = '0;
        cmd_if.posted_len = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            used_len_ring[i] = '0;
            used_len_valid[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_queue_not_ready();
        test_bad_chain_totals();
        test_reclaim_empty();
        test_chain_elements();
        test_post_and_reclaim();
        test_resize_mid_chain();
        test_device_overrun();
        test_random_traffic();

        drain_ring();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
